### hw/rtl/cap_pkg.sv
// ----------------------------------------------------------------------------
// cap_pkg: shared types and constants of the custom alphabet integer parser
// Command kinds, parse phases and the character codes the parser looks for.
// ----------------------------------------------------------------------------
`default_nettype none

package cap_pkg;

  // Command carried by each input beat.
  typedef enum logic [1:0] {
    KIND_CLEAR  = 2'd0,
    KIND_APPEND = 2'd1,
    KIND_TEXT   = 2'd2
  } kind_t;

  // Where the parser stands inside the current string.
  typedef enum logic [1:0] {
    PHASE_PREFIX = 2'd0,
    PHASE_DIGITS = 2'd1,
    PHASE_SKIP   = 2'd2
  } phase_t;

  localparam logic [7:0] CHAR_NUL   = 8'd0;
  localparam logic [7:0] CHAR_TAB   = 8'd9;
  localparam logic [7:0] CHAR_CR    = 8'd13;
  localparam logic [7:0] CHAR_SPACE = 8'd32;
  localparam logic [7:0] CHAR_PLUS  = 8'd43;
  localparam logic [7:0] CHAR_MINUS = 8'd45;
  localparam logic [7:0] CHAR_DEL   = 8'd127;

  // Smallest alphabet that forms a usable base.
  localparam logic [6:0] MIN_BASE = 7'd2;

endpackage

`default_nettype wire

### hw/rtl/cap_in_if.sv
// ----------------------------------------------------------------------------
// cap_in_if: input channel of the custom alphabet integer parser
// One beat carries a command kind and a raw byte.
// ----------------------------------------------------------------------------
`default_nettype none

interface cap_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] symbol;

  modport source (output valid, output kind, output symbol, input ready);
  modport sink   (input valid, input kind, input symbol, output ready);
endinterface

`default_nettype wire

### hw/rtl/cap_out_if.sv
// ----------------------------------------------------------------------------
// cap_out_if: result channel of the custom alphabet integer parser
// One beat carries a parsed value and the base validity flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface cap_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] value;
  logic               base_ok;

  modport source (output valid, output value, output base_ok, input ready);
  modport sink   (input valid, input value, input base_ok, output ready);
endinterface

`default_nettype wire

### hw/rtl/custom_alphabet_integer_parser_core.sv
// ----------------------------------------------------------------------------
// custom_alphabet_integer_parser_core: integer parser over a programmable alphabet
// A number's last byte passes the stage register and then the output register.
// Throughput: one input beat per cycle (single multiply-add) while results drain.
// Reset: synchronous rst empties the alphabet and restarts in the prefix phase.
// ----------------------------------------------------------------------------
`default_nettype none

// The block has two register stages.
//
// Acceptance edge: alphabet edits take effect here. Clear and append beats
// update the membership bits, the alphabet length and the bad flag, and an
// append writes its digit value into the digit memory. A text beat samples
// its membership bit, the current length and the base validity, and reads
// its digit value from the memory into the stage register. Since every edit
// is applied at the edge where it is accepted, a text beat always sees all
// edits made before it, and the memory read never collides with a write of
// the same beat.
//
// Parse stage: the staged text byte walks the prefix / digits / skip phases
// and performs one multiply-add on the accumulator. When it ends a number,
// the signed result goes into the output register. The stage advances
// whenever the output register is empty or being drained in that cycle, so
// a result that leaves in the same cycle costs no input beat. A result that
// the receiver holds back stops the stage, and the input stalls as soon as
// the stage register is occupied as well.
module custom_alphabet_integer_parser_core #(
  parameter int VALUE_WIDTH = 32
) (
  input  wire         clk,
  input  wire         rst,
  cap_in_if.sink      feed,
  cap_out_if.source   result
);

  // --------------------------------------------------------------------------
  // Alphabet state
  // --------------------------------------------------------------------------
  logic [255:0] in_alpha;
  logic [6:0]   alpha_len;
  logic         alpha_bad;
  logic [6:0]   digit_mem [256];

  // --------------------------------------------------------------------------
  // Stage register for a text byte
  // --------------------------------------------------------------------------
  logic       s1_valid;
  logic [7:0] s1_symbol;
  logic       s1_in_alpha;
  logic       s1_ok;
  logic [6:0] s1_len;
  logic [6:0] s1_digit;

  // --------------------------------------------------------------------------
  // Parse state
  // --------------------------------------------------------------------------
  cap_pkg::phase_t          phase;
  cap_pkg::phase_t          phase_next;
  logic                     parity;
  logic                     parity_next;
  logic [VALUE_WIDTH-1:0]   acc;
  logic [VALUE_WIDTH-1:0]   acc_next;

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  logic               out_valid;
  logic signed [31:0] out_value;
  logic               out_base_ok;

  // --------------------------------------------------------------------------
  // Handshake
  // --------------------------------------------------------------------------
  logic          accept;
  logic          s1_adv;
  cap_pkg::kind_t in_kind;

  assign in_kind    = cap_pkg::kind_t'(feed.kind);
  assign s1_adv     = s1_valid && (!out_valid || result.ready);
  assign feed.ready = !s1_valid || s1_adv;
  assign accept     = feed.valid && feed.ready;

  // An appended byte is rejected when it is a control character, space,
  // DEL or above, a sign character, or already in the alphabet.
  logic sym_rejected;
  assign sym_rejected = (feed.symbol <= cap_pkg::CHAR_SPACE)
                     || (feed.symbol >= cap_pkg::CHAR_DEL)
                     || (feed.symbol == cap_pkg::CHAR_PLUS)
                     || (feed.symbol == cap_pkg::CHAR_MINUS)
                     || in_alpha[feed.symbol];

  logic is_clear;
  logic is_append;
  logic is_text;

  always_comb begin
    is_clear  = 1'b0;
    is_append = 1'b0;
    is_text   = 1'b0;
    unique case (in_kind)
      cap_pkg::KIND_CLEAR:  is_clear  = 1'b1;
      cap_pkg::KIND_APPEND: is_append = 1'b1;
      cap_pkg::KIND_TEXT:   is_text   = 1'b1;
      default: ;
    endcase
  end

  // Alphabet bookkeeping, applied at the acceptance edge.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_alpha  <= '0;
      alpha_len <= '0;
      alpha_bad <= 1'b0;
    end else if (accept && is_clear) begin
      in_alpha  <= '0;
      alpha_len <= '0;
      alpha_bad <= 1'b0;
    end else if (accept && is_append) begin
      if (sym_rejected) begin
        alpha_bad <= 1'b1;
      end else begin
        in_alpha[feed.symbol] <= 1'b1;
        alpha_len             <= alpha_len + 7'd1;
      end
    end
  end

  // Digit memory: written by an accepted valid append, read on every accepted
  // beat. Entries are only used for bytes whose membership bit is set.
  always_ff @(posedge clk) begin
    if (accept && is_append && !sym_rejected) begin
      digit_mem[feed.symbol] <= alpha_len;
    end
    if (accept) begin
      s1_digit <= digit_mem[feed.symbol];
    end
  end

  // Stage register. Only text bytes occupy it; edits are finished on entry.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= is_text;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_symbol   <= feed.symbol;
      s1_in_alpha <= in_alpha[feed.symbol];
      s1_ok       <= !alpha_bad && (alpha_len >= cap_pkg::MIN_BASE);
      s1_len      <= alpha_len;
    end
  end

  // --------------------------------------------------------------------------
  // Parse stage
  // --------------------------------------------------------------------------
  logic is_nul;
  logic is_blank;
  logic is_plus;
  logic is_minus;
  logic digit_hit;
  logic prefix_skip;

  assign is_nul    = (s1_symbol == cap_pkg::CHAR_NUL);
  assign is_blank  = ((s1_symbol >= cap_pkg::CHAR_TAB) && (s1_symbol <= cap_pkg::CHAR_CR))
                  || (s1_symbol == cap_pkg::CHAR_SPACE);
  assign is_plus   = (s1_symbol == cap_pkg::CHAR_PLUS);
  assign is_minus  = (s1_symbol == cap_pkg::CHAR_MINUS);
  assign digit_hit = !is_nul && s1_in_alpha;

  // In the prefix phase, blanks and signs are consumed before any digit test.
  assign prefix_skip = (phase == cap_pkg::PHASE_PREFIX) && (is_blank || is_plus || is_minus);

  // One multiply-add per byte; the product wraps to the accumulator width.
  logic [VALUE_WIDTH-1:0] acc_mul;
  logic [VALUE_WIDTH-1:0] acc_step;

  assign acc_mul  = acc * VALUE_WIDTH'(s1_len);
  assign acc_step = acc_mul + VALUE_WIDTH'(s1_digit);

  // Next parse state.
  always_comb begin
    phase_next  = phase;
    parity_next = parity;
    acc_next    = acc;
    unique case (phase)
      cap_pkg::PHASE_SKIP: begin
        if (is_nul) begin
          phase_next  = cap_pkg::PHASE_PREFIX;
          parity_next = 1'b0;
          acc_next    = '0;
        end
      end
      cap_pkg::PHASE_PREFIX,
      cap_pkg::PHASE_DIGITS: begin
        if (prefix_skip) begin
          if (is_minus) begin
            parity_next = ~parity;
          end
        end else if (digit_hit) begin
          acc_next   = acc_step;
          phase_next = cap_pkg::PHASE_DIGITS;
        end else if (is_nul) begin
          phase_next  = cap_pkg::PHASE_PREFIX;
          parity_next = 1'b0;
          acc_next    = '0;
        end else begin
          phase_next = cap_pkg::PHASE_SKIP;
        end
      end
      default: begin
        phase_next  = cap_pkg::PHASE_PREFIX;
        parity_next = 1'b0;
        acc_next    = '0;
      end
    endcase
  end

  // Result generation: any non-digit that ends the prefix or digit run.
  logic                   emit;
  logic [VALUE_WIDTH-1:0] value_full;

  always_comb begin
    emit = 1'b0;
    unique case (phase)
      cap_pkg::PHASE_PREFIX,
      cap_pkg::PHASE_DIGITS: emit = !prefix_skip && !digit_hit;
      default:               emit = 1'b0;
    endcase
  end

  always_comb begin
    if (!s1_ok) begin
      value_full = '0;
    end else if (parity) begin
      value_full = '0 - acc;
    end else begin
      value_full = acc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase  <= cap_pkg::PHASE_PREFIX;
      parity <= 1'b0;
      acc    <= '0;
    end else if (s1_adv) begin
      phase  <= phase_next;
      parity <= parity_next;
      acc    <= acc_next;
    end
  end

  // Output register: a narrower accumulator zero-extends, a wider one
  // keeps its low 32 bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv && emit) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && emit) begin
      out_value   <= 32'(value_full);
      out_base_ok <= s1_ok;
    end
  end

  assign result.valid   = out_valid;
  assign result.value   = out_value;
  assign result.base_ok = out_base_ok;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_bad_base_zero: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.base_ok |-> result.value == 32'sd0)
    else $error("result with a bad base carries a nonzero value");

  a_nul_restarts: assert property (@(posedge clk) disable iff (rst)
    s1_adv && is_nul |=> phase == cap_pkg::PHASE_PREFIX && !parity && acc == '0)
    else $error("string end did not restart the parse");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    accept && is_clear |=> alpha_len == 7'd0 && !alpha_bad && in_alpha == '0)
    else $error("alphabet clear left state behind");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !feed.ready |-> s1_valid && out_valid && !result.ready)
    else $error("input stalled without a full pipeline");

endmodule

`default_nettype wire
